FILE: rtl/vna_pkg.sv
// vna_pkg: shared types and constants for the vertex normal accumulator.
// Used by vna_norm and vertex_normal_accumulator_top.
package vna_pkg;

   localparam int DEF_MAX_VERTICES = 64;

   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_TRI    = 2'd1;
   localparam logic [1:0] REQ_FINISH = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [5:0]         vertex_index;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic signed [15:0] coord_z;
      logic [5:0]         corner_a;
      logic [5:0]         corner_b;
      logic [5:0]         corner_c;
   } req_type_type;

   typedef struct packed {
      logic [5:0]         out_vertex;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic               degenerate;
      logic               last;
   } rsp_type;

endpackage

FILE: rtl/vna_norm.sv
// vna_norm: scales one accumulated 48-bit vector to a Q1.14 unit normal.
// Depends on vna_pkg. Multi-cycle: shift, squares, bit-serial root, serial divides.
module vna_norm
   import vna_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] sum_x,
   input  logic [47:0] sum_y,
   input  logic [47:0] sum_z,
   output logic        done,
   output logic [15:0] nx,
   output logic [15:0] ny,
   output logic [15:0] nz,
   output logic        degen
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SHIFT = 3'd1;
   localparam logic [2:0] S_SQ = 3'd2;
   localparam logic [2:0] S_ROOT = 3'd3;
   localparam logic [2:0] S_DIV = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  sgn_ff, sgn_in;
   logic [47:0] m_ff [3];
   logic [47:0] m_in [3];
   logic [63:0] sq_ff, sq_in;
   logic [1:0]  sqi_ff, sqi_in;
   logic [63:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [1:0]  di_ff, di_in;
   logic [45:0] num_ff, num_in;
   logic [31:0] dr_ff, dr_in;
   logic [45:0] q_ff, q_in;
   logic [15:0] o_ff [3];
   logic [15:0] o_in [3];
   logic        degen_ff, degen_in;

   logic [47:0] big;
   logic [47:0] ab [3];
   logic [65:0] trial;
   logic [32:0] dtrial;
   logic [15:0] qs;
   logic [29:0] sq_op;
   logic [59:0] sq_prod;

   always_comb begin
      big = m_ff[0];
      if (m_ff[1] > big) big = m_ff[1];
      if (m_ff[2] > big) big = m_ff[2];
      ab[0] = sum_x[47] ? (~sum_x + 48'd1) : sum_x;
      ab[1] = sum_y[47] ? (~sum_y + 48'd1) : sum_y;
      ab[2] = sum_z[47] ? (~sum_z + 48'd1) : sum_z;
      sq_op = m_ff[sqi_ff][29:0];
      sq_prod = sq_op * sq_op;
   end

   always_comb begin
      state_in = state_ff; sgn_in = sgn_ff; m_in = m_ff; sq_in = sq_ff; sqi_in = sqi_ff;
      rem_in = rem_ff; root_in = root_ff; cnt_in = cnt_ff; di_in = di_ff; num_in = num_ff;
      dr_in = dr_ff; q_in = q_ff; o_in = o_ff; degen_in = degen_ff;
      trial = '0; dtrial = '0; qs = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               m_in = ab;
               sgn_in = {sum_z[47], sum_y[47], sum_x[47]};
               degen_in = 1'b0;
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // one bit per cycle toward [2^29, 2^30)
            if (big == '0) begin
               degen_in = 1'b1;
               o_in[0] = '0; o_in[1] = '0; o_in[2] = '0;
               state_in = S_DONE;
            end else if (big >= 48'h4000_0000) begin
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] >> 1;
            end else if (big < 48'h2000_0000) begin
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] << 1;
            end else begin
               sq_in = '0; sqi_in = '0; state_in = S_SQ;
            end
         end
         S_SQ: begin
            sq_in = sq_ff + 64'(sq_prod);
            sqi_in = sqi_ff + 2'd1;
            if (sqi_ff == 2'd2) begin
               rem_in = '0; root_in = '0; cnt_in = 6'd32; state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            // restoring root, two radicand bits per cycle
            trial = {rem_ff, sq_ff[63:62]} - {32'd0, root_ff, 2'b01};
            if (!trial[65]) begin
               rem_in = trial[63:0]; root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in = {rem_ff[61:0], sq_ff[63:62]}; root_in = {root_ff[30:0], 1'b0};
            end
            sq_in = {sq_ff[61:0], 2'b00};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               di_in = '0; state_in = S_DIV;
               num_in = {m_ff[0][29:0], 14'd0} + 46'(root_in >> 1);
               dr_in = '0; q_in = '0; cnt_in = 6'd46;
            end
         end
         default: begin
            if (state_ff == S_DIV) begin
               dtrial = {dr_ff, num_ff[45]} - {1'b0, root_ff};
               if (!dtrial[32]) begin
                  dr_in = dtrial[31:0]; q_in = {q_ff[44:0], 1'b1};
               end else begin
                  dr_in = {dr_ff[30:0], num_ff[45]}; q_in = {q_ff[44:0], 1'b0};
               end
               num_in = {num_ff[44:0], 1'b0};
               cnt_in = cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) begin
                  qs = (q_in > 46'd16384) ? 16'd16384 : q_in[15:0];
                  o_in[di_ff] = sgn_ff[di_ff] ? (~qs + 16'd1) : qs;
                  if (di_ff == 2'd2) state_in = S_DONE;
                  else begin
                     di_in = di_ff + 2'd1;
                     num_in = {m_ff[di_in][29:0], 14'd0} + 46'(root_ff >> 1);
                     dr_in = '0; q_in = '0; cnt_in = 6'd46;
                  end
               end
            end else begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
      sgn_ff <= sgn_in; m_ff <= m_in; sq_ff <= sq_in; sqi_ff <= sqi_in; rem_ff <= rem_in;
      root_ff <= root_in; cnt_ff <= cnt_in; di_ff <= di_in; num_ff <= num_in;
      dr_ff <= dr_in; q_ff <= q_in; o_ff <= o_in; degen_ff <= degen_in;
   end

   assign done = (state_ff == S_DONE);
   assign nx = o_ff[0];
   assign ny = o_ff[1];
   assign nz = o_ff[2];
   assign degen = degen_ff;

endmodule

FILE: rtl/vertex_normal_accumulator_top.sv
// vertex_normal_accumulator_top: area-weighted vertex normals over memories.
// Depends on vna_pkg and vna_norm.
//
//  channel | ports                       | handshake
//  req     | start, busy, req_data       | taken when start && !busy
//  rsp     | rsp_valid, rsp_data         | one-cycle strobe, cannot stall
//  csr     | csr_we, csr_wdata           | written when csr_we
//
// Load: busy stays low. Triangle: three position reads, edges, products,
// then three read-modify-writes of the sum memory. Finish: per vertex, a
// read of the sums, then the normalizing shift, the serial root and three
// serial divides in vna_norm; then a clearing sweep of the sum memory.
// After reset a sweep clears the sums (busy high).
module vertex_normal_accumulator_top
   import vna_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_type_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  logic         csr_we,
   input  logic [6:0]   csr_wdata
);

   localparam int AW = $clog2(MAX_VERTICES);

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_PRD   = 4'd2;
   localparam logic [3:0] S_EDGE  = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_RD    = 4'd5;
   localparam logic [3:0] S_WR    = 4'd6;
   localparam logic [3:0] S_FRD   = 4'd7;
   localparam logic [3:0] S_FNRM  = 4'd8;
   localparam logic [3:0] S_FWAIT = 4'd9;

   logic [47:0] pos_mem [MAX_VERTICES];
   logic [143:0] sum_mem [MAX_VERTICES];
   logic [47:0]  pos_q;
   logic [143:0] sum_q;

   logic [3:0]  state_ff, state_in;
   logic [6:0]  vcount_ff;
   logic [6:0]  cnt_ff, cnt_in;
   logic [1:0]  k_ff, k_in;
   logic [AW-1:0] corner_ff [3];
   logic [47:0] p_ff [3];
   logic [47:0] p_in [3];
   logic signed [16:0] e_ff [6];
   logic signed [16:0] e_in [6];
   logic signed [34:0] pr_ff [6];
   logic signed [34:0] pr_in [6];
   logic [47:0] n_ff [3];
   logic [47:0] n_in [3];
   logic [AW-1:0] raddr_pos, raddr_sum, waddr_sum;
   logic        we_sum;
   logic [143:0] wdata_sum;
   logic [6:0]  eff;
   logic        norm_start, norm_done, norm_degen;
   logic [15:0] norm_x, norm_y, norm_z;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   logic        corner_ok;

   assign eff = (vcount_ff > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vcount_ff;
   assign corner_ok = (7'(req_data.corner_a) < eff) && (7'(req_data.corner_b) < eff)
                      && (7'(req_data.corner_c) < eff);

   always_ff @(posedge clock) begin
      if (reset) vcount_ff <= 7'd64;
      else if (csr_we) vcount_ff <= csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (start && !busy && req_data.req_type == REQ_LOAD
          && 7'(req_data.vertex_index) < 7'(MAX_VERTICES))
         pos_mem[req_data.vertex_index[AW-1:0]] <=
            {req_data.coord_z, req_data.coord_y, req_data.coord_x};
      pos_q <= pos_mem[raddr_pos];
   end

   always_ff @(posedge clock) begin
      if (we_sum) sum_mem[waddr_sum] <= wdata_sum;
      sum_q <= sum_mem[raddr_sum];
   end

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; k_in = k_ff; p_in = p_ff; e_in = e_ff;
      pr_in = pr_ff; n_in = n_ff;
      raddr_pos = corner_ff[k_ff]; raddr_sum = corner_ff[k_ff];
      waddr_sum = corner_ff[k_ff]; we_sum = 1'b0; wdata_sum = '0;
      norm_start = 1'b0;
      unique case (state_ff)
         S_CLR: begin
            we_sum = 1'b1; waddr_sum = cnt_ff[AW-1:0];
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(MAX_VERTICES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               if (req_data.req_type == REQ_TRI && corner_ok) begin
                  k_in = '0; state_in = S_PRD;
               end else if (req_data.req_type == REQ_FINISH) begin
                  cnt_in = '0;
                  state_in = (eff == '0) ? S_CLR : S_FRD;
               end
            end
         end
         S_PRD: begin
            // pos_q valid in the cycle after each address
            if (k_ff != 2'd0) p_in[k_ff - 2'd1] = pos_q;
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) state_in = S_EDGE;
         end
         S_EDGE: begin
            for (int i = 0; i < 3; i++) begin
               e_in[i]   = 17'(signed'(p_ff[1][16*i +: 16])) - 17'(signed'(p_ff[0][16*i +: 16]));
               e_in[i+3] = 17'(signed'(p_ff[2][16*i +: 16])) - 17'(signed'(p_ff[0][16*i +: 16]));
            end
            state_in = S_MUL;
         end
         S_MUL: begin
            pr_in[0] = e_ff[1] * e_ff[5]; pr_in[1] = e_ff[2] * e_ff[4];
            pr_in[2] = e_ff[2] * e_ff[3]; pr_in[3] = e_ff[0] * e_ff[5];
            pr_in[4] = e_ff[0] * e_ff[4]; pr_in[5] = e_ff[1] * e_ff[3];
            k_in = '0; state_in = S_RD;
         end
         S_RD: begin
            n_in[0] = 48'(pr_ff[0] - pr_ff[1]);
            n_in[1] = 48'(pr_ff[2] - pr_ff[3]);
            n_in[2] = 48'(pr_ff[4] - pr_ff[5]);
            state_in = S_WR;
         end
         S_WR: begin
            // one read then write per corner; serialized so repeats stay exact
            we_sum = 1'b1;
            wdata_sum = {sum_q[143:96] + n_ff[2], sum_q[95:48] + n_ff[1],
                         sum_q[47:0] + n_ff[0]};
            k_in = k_ff + 2'd1;
            state_in = (k_ff == 2'd2) ? S_IDLE : S_RD;
         end
         S_FRD: begin
            raddr_sum = cnt_ff[AW-1:0];
            state_in = S_FNRM;
         end
         S_FNRM: begin
            norm_start = 1'b1;
            state_in = S_FWAIT;
         end
         default: begin
            if (norm_done) begin
               cnt_in = cnt_ff + 7'd1;
               if (cnt_ff + 7'd1 == eff) begin
                  cnt_in = '0; state_in = S_CLR;
               end else state_in = S_FRD;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= (state_ff == S_FWAIT) && norm_done;
      end
      k_ff <= k_in; p_ff <= p_in; e_ff <= e_in; pr_ff <= pr_in; n_ff <= n_in;
      if (start && !busy) begin
         corner_ff[0] <= req_data.corner_a[AW-1:0];
         corner_ff[1] <= req_data.corner_b[AW-1:0];
         corner_ff[2] <= req_data.corner_c[AW-1:0];
      end
      rsp_ff.out_vertex <= cnt_ff[5:0];
      rsp_ff.normal_x <= norm_x;
      rsp_ff.normal_y <= norm_y;
      rsp_ff.normal_z <= norm_z;
      rsp_ff.degenerate <= norm_degen;
      rsp_ff.last <= (cnt_ff + 7'd1 == eff);
   end

   vna_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (norm_start),
      .sum_x (sum_q[47:0]),
      .sum_y (sum_q[95:48]),
      .sum_z (sum_q[143:96]),
      .done  (norm_done),
      .nx    (norm_x),
      .ny    (norm_y),
      .nz    (norm_z),
      .degen (norm_degen)
   );

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

FILE: test/testbench.sv
// Testbench for vertex_normal_accumulator_top: vertex loads, triangle adds and
// finish runs are checked against a behavioral normal predictor in this file.
// Depends on vna_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench
   import vna_pkg::*;
();

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_type_type req_data;
   logic         rsp_valid;
   rsp_type      rsp_data;
   logic         csr_we;
   logic [6:0]   csr_wdata;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int SLOT_COUNT = 64;

   // predictor state
   logic signed [15:0] pos_x [SLOT_COUNT];
   logic signed [15:0] pos_y [SLOT_COUNT];
   logic signed [15:0] pos_z [SLOT_COUNT];
   logic [47:0] acc_x [SLOT_COUNT];
   logic [47:0] acc_y [SLOT_COUNT];
   logic [47:0] acc_z [SLOT_COUNT];
   logic [6:0]  vtx_count;

   rsp_type pending_normals[$];
   int      errors;
   int      burst_left;

   vertex_normal_accumulator_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   initial begin
      #40ms;
      $display("status: fail");
      $finish;
   end

   function automatic int active_count();
      return (vtx_count > SLOT_COUNT) ? SLOT_COUNT : int'(vtx_count);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (n >= res + bit_v) begin
            n = n - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   function automatic rsp_type unit_normal_of(int idx);
      rsp_type r;
      longint s [3];
      longint unsigned m [3];
      longint unsigned big, len, q;
      r = '0;
      s[0] = longint'(signed'(acc_x[idx]));
      s[1] = longint'(signed'(acc_y[idx]));
      s[2] = longint'(signed'(acc_z[idx]));
      for (int i = 0; i < 3; i++) m[i] = (s[i] < 0) ? -s[i] : s[i];
      big = m[0];
      if (m[1] > big) big = m[1];
      if (m[2] > big) big = m[2];
      r.out_vertex = idx[5:0];
      r.last = (idx + 1 == active_count());
      if (big == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      while (big >= (64'd1 << 30)) begin
         big = big >> 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      while (big < (64'd1 << 29)) begin
         big = big << 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int i = 0; i < 3; i++) begin
         q = (m[i] * 16384 + (len >> 1)) / len;
         if (q > 16384) q = 16384;
         if (s[i] < 0) q = 17'h10000 - q;
         if (i == 0) r.normal_x = q[15:0];
         else if (i == 1) r.normal_y = q[15:0];
         else r.normal_z = q[15:0];
      end
      return r;
   endfunction

   task automatic predict_request(req_type_type rq);
      longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
      int cnt;
      int a, b, c;
      cnt = active_count();
      a = rq.corner_a;
      b = rq.corner_b;
      c = rq.corner_c;
      case (rq.req_type)
         REQ_LOAD: begin
            pos_x[rq.vertex_index] = rq.coord_x;
            pos_y[rq.vertex_index] = rq.coord_y;
            pos_z[rq.vertex_index] = rq.coord_z;
         end
         REQ_TRI: begin
            if (a < cnt && b < cnt && c < cnt) begin
               e1x = pos_x[b] - pos_x[a];
               e1y = pos_y[b] - pos_y[a];
               e1z = pos_z[b] - pos_z[a];
               e2x = pos_x[c] - pos_x[a];
               e2y = pos_y[c] - pos_y[a];
               e2z = pos_z[c] - pos_z[a];
               nx = e1y * e2z - e1z * e2y;
               ny = e1z * e2x - e1x * e2z;
               nz = e1x * e2y - e1y * e2x;
               foreach (acc_x[i]) begin
                  if (i == a || i == b || i == c) begin
                     // repeated corners add once per naming
                     repeat (int'(i == a) + int'(i == b) + int'(i == c)) begin
                        acc_x[i] = acc_x[i] + nx[47:0];
                        acc_y[i] = acc_y[i] + ny[47:0];
                        acc_z[i] = acc_z[i] + nz[47:0];
                     end
                  end
               end
            end
         end
         REQ_FINISH: begin
            for (int v = 0; v < cnt; v++) pending_normals.push_back(unit_normal_of(v));
            foreach (acc_x[i]) begin
               acc_x[i] = '0;
               acc_y[i] = '0;
               acc_z[i] = '0;
            end
         end
         default: ;
      endcase
   endtask

   // drives one request at the falling edge and waits for it to be taken
   task automatic send_request(req_type_type rq);
      req_data <= rq;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predict_request(rq);
      @(negedge clock);
   endtask

   // bursty sender: gaps between bursts of random length
   task automatic send_paced(req_type_type rq);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 15);
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
      burst_left--;
      send_request(rq);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_normals.size() != 0) @(negedge clock);
      // finish ends in a clearing sweep after the last normal
      repeat (100) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic write_count(logic [6:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      vtx_count = value;
   endtask

   function automatic req_type_type load_req(int idx, logic [15:0] x, logic [15:0] y,
                                             logic [15:0] z);
      req_type_type r;
      r = '0;
      r.req_type = REQ_LOAD;
      r.vertex_index = idx[5:0];
      r.coord_x = x;
      r.coord_y = y;
      r.coord_z = z;
      return r;
   endfunction

   function automatic req_type_type tri_req(int a, int b, int c);
      req_type_type r;
      r = 74'($urandom());
      r.coord_x = 16'($urandom());
      r.req_type = REQ_TRI;
      r.corner_a = a[5:0];
      r.corner_b = b[5:0];
      r.corner_c = c[5:0];
      return r;
   endfunction

   function automatic req_type_type finish_req();
      req_type_type r;
      r = '0;
      r.req_type = REQ_FINISH;
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_normals.size() == 0) begin
            $display("%0t: unexpected normal, actual %p", $realtime, rsp_data);
            errors++;
         end else begin
            rsp_type want;
            want = pending_normals.pop_front();
            if (rsp_data !== want) begin
               $display("%0t: normal mismatch, expected %p, actual %p",
                        $realtime, want, rsp_data);
               errors++;
            end
         end
      end
   end

   // every slot gets a position so no triangle reads an empty slot
   task automatic test_load_all();
      send_request(load_req(0, 16'h8000, 16'h8000, 16'h8000));
      send_request(load_req(1, 16'h7fff, 16'h8000, 16'h8000));
      send_request(load_req(2, 16'h8000, 16'h7fff, 16'h8000));
      send_request(load_req(3, 16'h0000, 16'h0000, 16'h7fff));
      for (int i = 4; i < SLOT_COUNT; i++)
         send_request(load_req(i, 16'($urandom()), 16'($urandom()), 16'($urandom())));
   endtask

   task automatic test_directed();
      send_request(tri_req(0, 1, 2));           // extreme coordinates
      send_request(tri_req(0, 1, 2));           // accumulator growth
      send_request(tri_req(1, 3, 63));
      send_request(tri_req(5, 5, 6));           // repeated corner
      send_request({REQ_UNUSED, 72'hffffffffffffffffff});
      send_request(finish_req());
      // immediate finish: every normal degenerate
      send_request(finish_req());
      wait_drained();
   endtask

   task automatic test_count_extremes();
      write_count(7'd1);
      send_request(tri_req(0, 1, 2));           // corner beyond count
      send_request(tri_req(0, 0, 0));
      send_request(finish_req());
      write_count(7'd0);
      send_request(tri_req(0, 0, 0));
      send_request(finish_req());               // no normals, still clears
      write_count(7'd127);                      // acts as the full size
      send_request(tri_req(2, 0, 1));
      send_request(finish_req());
      write_count(7'd3);
      send_request(tri_req(0, 1, 2));
      send_request(tri_req(2, 1, 0));
      send_request(finish_req());
   endtask

   task automatic test_random_phase(logic [6:0] count_value, int items, int finish_pct);
      int cnt, pick;
      req_type_type rq;
      write_count(count_value);
      cnt = active_count();
      for (int n = 0; n < items; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < finish_pct) begin
            rq = finish_req();
         end else if (pick < 30) begin
            rq = load_req($urandom_range(0, 63), 16'($urandom()), 16'($urandom()),
                          16'($urandom()));
         end else if (pick < 88) begin
            rq = tri_req($urandom_range(0, cnt - 1), $urandom_range(0, cnt - 1),
                         $urandom_range(0, cnt - 1));
         end else if (pick < 97) begin
            rq = tri_req($urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 63));
         end else begin
            rq = 74'($urandom());
            rq.req_type = REQ_UNUSED;
         end
         send_paced(rq);
         // occasional hold-off until the block has emitted everything
         if ($urandom_range(0, 40) == 0) wait_drained();
      end
      send_request(finish_req());
   endtask

   initial begin
      errors = 0;
      burst_left = 0;
      vtx_count = 7'd64;
      foreach (acc_x[i]) begin
         acc_x[i] = '0;
         acc_y[i] = '0;
         acc_z[i] = '0;
      end
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_load_all();
      test_directed();
      test_count_extremes();
      test_random_phase(7'd4, 40, 6);
      test_random_phase(7'd12, 40, 4);
      test_random_phase(7'd2, 30, 8);
      test_random_phase(7'd64, 35, 1);
      test_random_phase(7'd33, 20, 3);
      wait_drained();
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
